// ----- src/assert_macros.svh -----
// Assertion macros used by the RTL of the accumulator and MQ logic unit.
// Each use checks against clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AMSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define AMSL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/amsl_pkg.sv -----
// Package of the accumulator and MQ logic unit: command codes, field widths
// and the architectural state type. No dependencies.
`timescale 1ns / 1ps

package amsl_pkg;

  localparam int unsigned CmdW   = 5;
  localparam int unsigned WordW  = 36;
  localparam int unsigned CntW   = 8;
  localparam int unsigned AccW   = 38;
  localparam int unsigned SkipW  = 2;
  localparam int unsigned MaskW  = 18;
  localparam int unsigned RotW   = 6;

  typedef enum logic [CmdW-1:0] {
    CmdLgl = 5'd0,
    CmdLgr = 5'd1,
    CmdRql = 5'd2,
    CmdXcl = 5'd3,
    CmdAna = 5'd4,
    CmdOra = 5'd5,
    CmdCal = 5'd6,
    CmdLas = 5'd7,
    CmdNzt = 5'd8,
    CmdTnz = 5'd9,
    CmdTmi = 5'd10,
    CmdTno = 5'd11,
    CmdRia = 5'd12,
    CmdPia = 5'd13,
    CmdIil = 5'd14,
    CmdSil = 5'd15,
    CmdRil = 5'd16,
    CmdLft = 5'd17,
    CmdLnt = 5'd18
  } cmd_e;

  typedef struct packed {
    logic [AccW-1:0]  acc;
    logic [WordW-1:0] mq;
    logic [WordW-1:0] si;
    logic             ovf;
  } arch_state_t;

  typedef struct packed {
    logic [SkipW-1:0] skip;
    logic             branch;
  } flags_t;

  // Reduces a shift count modulo 36 by three conditional subtractions.
  function automatic logic [RotW-1:0] mod36(input logic [CntW-1:0] cnt);
    logic [CntW-1:0] v;
    v = cnt;
    if (v >= 8'd144) v = v - 8'd144;
    if (v >= 8'd72)  v = v - 8'd72;
    if (v >= 8'd36)  v = v - 8'd36;
    return v[RotW-1:0];
  endfunction

endpackage

// ----- src/amsl_if.sv -----
// Request and response channel interfaces of the accumulator and MQ logic unit.
// Depends on amsl_pkg for the field widths.
`timescale 1ns / 1ps

interface amsl_req_if;
  logic                            valid;
  logic                            ready;
  logic [amsl_pkg::CmdW-1:0]       command;
  logic [amsl_pkg::WordW-1:0]      mem_word;
  logic [amsl_pkg::CntW-1:0]       shift_count;

  modport source (output valid, command, mem_word, shift_count, input ready);
  modport sink (input valid, command, mem_word, shift_count, output ready);
endinterface

interface amsl_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [amsl_pkg::AccW-1:0]       acc_value;
  logic [amsl_pkg::WordW-1:0]      mq_value;
  logic [amsl_pkg::WordW-1:0]      indicators;
  logic                            overflow_flag;
  logic [amsl_pkg::SkipW-1:0]      skip_count;
  logic                            branch_taken;

  modport source (output valid, acc_value, mq_value, indicators, overflow_flag,
                  skip_count, branch_taken, input ready);
  modport sink (input valid, acc_value, mq_value, indicators, overflow_flag,
                skip_count, branch_taken, output ready);
endinterface

// ----- src/amsl_exec.sv -----
// Combinational execute stage: computes the next architectural state and the
// skip and branch flags of one instruction. Depends on amsl_pkg.
`timescale 1ns / 1ps

module amsl_exec (
  input  logic [amsl_pkg::CmdW-1:0]  cmd_i,
  input  logic [amsl_pkg::WordW-1:0] word_i,
  input  logic [amsl_pkg::CntW-1:0]  cnt_i,
  input  amsl_pkg::arch_state_t      cur_i,
  output amsl_pkg::arch_state_t      nxt_o,
  output amsl_pkg::flags_t           flags_o
);

  logic [72:0]                      pair;
  logic [72:0]                      lgl_pair;
  logic [72:0]                      lgr_pair;
  logic                             lgl_ovf;
  logic [71:0]                      rot;
  logic [amsl_pkg::WordW-1:0]       imask;
  logic [36:0]                      word_ext;

  assign pair     = {cur_i.acc[36:0], cur_i.mq};
  assign lgl_pair = pair << cnt_i;
  assign lgr_pair = pair >> cnt_i;
  // A one passes through P if it starts within cnt places below it.
  assign lgl_ovf  = |(pair[70:0] & ~({71{1'b1}} >> cnt_i));
  assign rot      = {cur_i.mq, cur_i.mq} << amsl_pkg::mod36(cnt_i);
  assign imask    = {word_i[amsl_pkg::MaskW-1:0], {amsl_pkg::MaskW{1'b0}}};
  assign word_ext = {1'b0, word_i};

  always_comb begin
    nxt_o          = cur_i;
    flags_o.skip   = '0;
    flags_o.branch = 1'b0;
    case (amsl_pkg::cmd_e'(cmd_i))
      amsl_pkg::CmdLgl: begin
        nxt_o.acc = {cur_i.acc[37], lgl_pair[72:36]};
        nxt_o.mq  = lgl_pair[35:0];
        nxt_o.ovf = cur_i.ovf | lgl_ovf;
      end
      amsl_pkg::CmdLgr: begin
        nxt_o.acc = {cur_i.acc[37], lgr_pair[72:36]};
        nxt_o.mq  = lgr_pair[35:0];
      end
      amsl_pkg::CmdRql: nxt_o.mq = rot[71:36];
      amsl_pkg::CmdXcl: begin
        nxt_o.acc = {2'b00, cur_i.mq};
        nxt_o.mq  = cur_i.acc[35:0];
      end
      amsl_pkg::CmdAna: nxt_o.acc = {2'b00, cur_i.acc[35:0] & word_i};
      amsl_pkg::CmdOra: nxt_o.acc = {cur_i.acc[37:36], cur_i.acc[35:0] | word_i};
      amsl_pkg::CmdCal: nxt_o.acc = {2'b00, word_i};
      amsl_pkg::CmdLas: begin
        if (cur_i.acc[36:0] < word_ext) begin
          flags_o.skip = 2'd2;
        end else if (cur_i.acc[36:0] == word_ext) begin
          flags_o.skip = 2'd1;
        end
      end
      amsl_pkg::CmdNzt: flags_o.skip = {1'b0, |word_i[34:0]};
      amsl_pkg::CmdTnz: flags_o.branch = |cur_i.acc[36:0];
      amsl_pkg::CmdTmi: flags_o.branch = cur_i.acc[37];
      amsl_pkg::CmdTno: begin
        flags_o.branch = ~cur_i.ovf;
        nxt_o.ovf      = 1'b0;
      end
      amsl_pkg::CmdRia: nxt_o.si = cur_i.si & ~cur_i.acc[35:0];
      amsl_pkg::CmdPia: nxt_o.acc = {2'b00, cur_i.si};
      amsl_pkg::CmdIil: nxt_o.si = cur_i.si ^ imask;
      amsl_pkg::CmdSil: nxt_o.si = cur_i.si | imask;
      amsl_pkg::CmdRil: nxt_o.si = cur_i.si & ~imask;
      amsl_pkg::CmdLft: flags_o.skip = {1'b0, (cur_i.si & imask) == '0};
      amsl_pkg::CmdLnt: flags_o.skip = {1'b0, (cur_i.si & imask) == imask};
      default: ;
    endcase
  end

endmodule

// ----- src/accumulator_mq_shift_logic_unit_core.sv -----
// A request is registered at acceptance, then executed once the response
// register is free. Throughput: one request per cycle while rsp_o.ready is
// high; the state registers feed the execute logic directly, so each
// request sees the state left by the one before.
// Reset: rst_ni clears AC, MQ, the indicators, overflow and both valid flags.
// Depends on amsl_pkg, amsl_if, amsl_exec and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module accumulator_mq_shift_logic_unit_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  amsl_req_if.sink          req_i,
  amsl_rsp_if.source        rsp_o
);

  logic                          in_vld_q;
  logic [amsl_pkg::CmdW-1:0]     cmd_q;
  logic [amsl_pkg::WordW-1:0]    word_q;
  logic [amsl_pkg::CntW-1:0]     cnt_q;
  logic                          out_vld_q;
  amsl_pkg::flags_t              flags_q;
  amsl_pkg::flags_t              flags_d;
  amsl_pkg::arch_state_t         state_q;
  amsl_pkg::arch_state_t         state_d;
  logic                          exec_fire;
  logic                          in_fire;

  assign exec_fire   = in_vld_q & (~out_vld_q | rsp_o.ready);
  assign req_i.ready = ~in_vld_q | exec_fire;
  assign in_fire     = req_i.valid & req_i.ready;

  amsl_exec u_exec (
    .cmd_i   (cmd_q),
    .word_i  (word_q),
    .cnt_i   (cnt_q),
    .cur_i   (state_q),
    .nxt_o   (state_d),
    .flags_o (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (req_i.ready) begin
        in_vld_q <= req_i.valid;
      end
      if (exec_fire) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= req_i.command;
      word_q <= req_i.mem_word;
      cnt_q  <= req_i.shift_count;
    end
    if (exec_fire) begin
      flags_q <= flags_d;
    end
  end

  // The state registers change only when a new response is loaded, so they
  // hold the state after the request on display.
  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.acc_value     = state_q.acc;
  assign rsp_o.mq_value      = state_q.mq;
  assign rsp_o.indicators    = state_q.si;
  assign rsp_o.overflow_flag = state_q.ovf;
  assign rsp_o.skip_count    = flags_q.skip;
  assign rsp_o.branch_taken  = flags_q.branch;

  `AMSL_ASSERT_NXT(a_fire_gives_rsp, exec_fire, rsp_o.valid)
  `AMSL_ASSERT_NXT(a_stall_holds_state, rsp_o.valid && !rsp_o.ready, $stable(state_q))
  `AMSL_ASSERT_NXT(a_tno_clears_ovf, exec_fire && cmd_q == amsl_pkg::CmdTno, !state_q.ovf)
  `AMSL_ASSERT_IMP(a_skip_range, rsp_o.valid, rsp_o.skip_count != 2'd3)

endmodule
